/* sv/cfdd_pkg.sv */
// Shared types and constants for the cockpit frame deframer and control decoder.
package cfdd_pkg;

    localparam int MAX_FRAME_LEN = 64;
    localparam int DECODE_LEN    = 14;
    localparam int HDR_LEN       = 4;
    localparam int PAYLOAD_DEPTH = DECODE_LEN - HDR_LEN;

    localparam logic [1:0] FUNC_BYTE       = 2'd0;
    localparam logic [1:0] FUNC_TICK       = 2'd1;
    localparam logic [1:0] FUNC_LINK_RESET = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_TOO_SHORT = 2'd1;
    localparam logic [1:0] STATUS_BAD_VER   = 2'd2;

    localparam logic [1:0] CFG_PROTOCOL_VERSION = 2'd0;
    localparam logic [1:0] CFG_TAKEOVER_HOLDOFF = 2'd1;

    localparam logic [7:0]  PROTOCOL_VERSION_RESET = 8'h0C;
    localparam logic [15:0] TAKEOVER_HOLDOFF_RESET = 16'd300;

    localparam int STEER_MAX = 10000;

    typedef struct packed {
        logic        done;
        logic        too_short;
        logic [7:0]  version;
        logic [7:0]  b4;
        logic [7:0]  b6;
        logic [7:0]  b7;
        logic [15:0] steer_raw;
        logic [7:0]  throttle;
        logic [7:0]  brake;
    } frame_t;

    typedef struct packed {
        logic               valid;
        logic [1:0]         frame_status;
        logic               first_data;
        logic [13:0]        steer_position;
        logic [14:0]        throttle_scaled;
        logic [14:0]        brake_scaled;
        logic               emergency_stop;
        logic [1:0]         gear_select;
        logic [7:0]         lamp_bits;
        logic               takeover_event;
        logic signed [15:0] raw_steering;
        logic [7:0]         raw_throttle;
        logic [7:0]         raw_brake;
    } result_t;

endpackage

/* sv/cfdd_deframer.sv */
// Header hunting, frame byte counting and payload capture.
module cfdd_deframer #(
    parameter int MAX_FRAME_LEN = cfdd_pkg::MAX_FRAME_LEN
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  logic [1:0]        func,
    input  logic [7:0]        rx_byte,
    output cfdd_pkg::frame_t  frame
);

    localparam int CW = $clog2(MAX_FRAME_LEN + 1);
    localparam int PD = cfdd_pkg::PAYLOAD_DEPTH;

    logic [7:0]    window_reg [0:cfdd_pkg::HDR_LEN-1];
    logic [7:0]    window_next [0:cfdd_pkg::HDR_LEN-1];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [7:0]    payload_reg [0:PD-1];
    logic          payload_we;
    logic [3:0]    payload_idx;
    logic [CW-1:0] count_inc;
    logic [7:0]    len;
    logic          done;

    always_comb begin
        for (int i = 0; i < cfdd_pkg::HDR_LEN; i++) begin
            window_next[i] = window_reg[i];
        end
        count_next  = count_reg;
        count_inc   = count_reg + CW'(1);
        payload_we  = 1'b0;
        payload_idx = count_reg[3:0] - 4'(cfdd_pkg::HDR_LEN);
        len         = window_reg[3];
        done        = 1'b0;
        if (advance) begin
            case (func)
                cfdd_pkg::FUNC_BYTE: begin
                    if (count_reg < CW'(cfdd_pkg::HDR_LEN)) begin
                        window_next[count_reg[1:0]] = rx_byte;
                        if (count_reg == CW'(cfdd_pkg::HDR_LEN - 1)) begin
                            len = rx_byte;
                            if (rx_byte < 8'(cfdd_pkg::HDR_LEN) ||
                                rx_byte > 8'(MAX_FRAME_LEN)) begin
                                window_next[0] = window_reg[1];
                                window_next[1] = window_reg[2];
                                window_next[2] = rx_byte;
                                count_next     = CW'(cfdd_pkg::HDR_LEN - 1);
                            end else if (rx_byte == 8'(cfdd_pkg::HDR_LEN)) begin
                                done       = 1'b1;
                                count_next = '0;
                            end else begin
                                count_next = count_inc;
                            end
                        end else begin
                            count_next = count_inc;
                        end
                    end else begin
                        if (count_reg < CW'(cfdd_pkg::DECODE_LEN)) begin
                            payload_we = 1'b1;
                        end
                        if (8'(count_inc) >= len) begin
                            done       = 1'b1;
                            count_next = '0;
                        end else begin
                            count_next = count_inc;
                        end
                    end
                end
                cfdd_pkg::FUNC_LINK_RESET: begin
                    count_next = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < cfdd_pkg::HDR_LEN; i++) begin
                window_reg[i] <= '0;
            end
            count_reg <= '0;
        end else begin
            for (int i = 0; i < cfdd_pkg::HDR_LEN; i++) begin
                window_reg[i] <= window_next[i];
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (payload_we) begin
            payload_reg[payload_idx] <= rx_byte;
        end
    end

    always_comb begin
        frame.done      = done;
        frame.too_short = len < 8'(cfdd_pkg::DECODE_LEN);
        frame.version   = window_reg[0];
        frame.b4        = payload_reg[0];
        frame.b6        = payload_reg[2];
        frame.b7        = payload_reg[3];
        frame.steer_raw = {payload_reg[6], payload_reg[5]};
        frame.throttle  = payload_reg[7];
        frame.brake     = payload_reg[8];
    end

endmodule

/* sv/cfdd_decode.sv */
// Control decoding, first-data tracking and takeover holdoff timing.
module cfdd_decode (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  logic [1:0]        func,
    input  cfdd_pkg::frame_t  frame,
    input  logic [7:0]        protocol_version,
    input  logic [15:0]       takeover_holdoff_ms,
    output cfdd_pkg::result_t result
);

    logic        valid_seen_reg;
    logic        valid_seen_next;
    logic        was_pressed_reg;
    logic        was_pressed_next;
    logic [31:0] ms_counter_reg;
    logic [31:0] ms_counter_next;
    logic [31:0] last_event_reg;
    logic [31:0] last_event_next;

    logic signed [15:0] steer_s;
    logic [9:0]         steer_x;
    logic [9:0]         steer_x4;
    logic [19:0]        steer_prod;
    logic [13:0]        steer_lin;
    logic [13:0]        steer_pos;
    logic [31:0]        elapsed;
    logic               pressed;
    logic [1:0]         gear;

    // floor((100x + 4) / 9) = 11x + floor((x + 4) / 9), the last by reciprocal.
    always_comb begin
        steer_s    = signed'(frame.steer_raw);
        steer_x    = 10'(frame.steer_raw + 16'd450);
        steer_x4   = steer_x + 10'd4;
        steer_prod = 20'(steer_x4) * 20'd911;
        steer_lin  = 14'({steer_x, 3'b000}) + 14'({steer_x, 1'b0}) + 14'(steer_x)
                   + 14'(steer_prod[19:13]);
        if (steer_s <= -16'sd450) begin
            steer_pos = '0;
        end else if (steer_s >= 16'sd450) begin
            steer_pos = 14'(cfdd_pkg::STEER_MAX);
        end else begin
            steer_pos = steer_lin;
        end
        if (frame.b4[2]) begin
            gear = 2'd1;
        end else if (frame.b4[1]) begin
            gear = 2'd2;
        end else begin
            gear = 2'd0;
        end
        pressed = frame.b4[3];
        elapsed = ms_counter_reg - last_event_reg;
    end

    always_comb begin
        valid_seen_next  = valid_seen_reg;
        was_pressed_next = was_pressed_reg;
        ms_counter_next  = ms_counter_reg;
        last_event_next  = last_event_reg;
        result           = '0;
        if (advance) begin
            case (func)
                cfdd_pkg::FUNC_TICK: begin
                    ms_counter_next = ms_counter_reg + 32'd1;
                end
                cfdd_pkg::FUNC_LINK_RESET: begin
                    valid_seen_next = 1'b0;
                end
                cfdd_pkg::FUNC_BYTE: begin
                    if (frame.done) begin
                        result.valid = 1'b1;
                        if (frame.too_short) begin
                            result.frame_status = cfdd_pkg::STATUS_TOO_SHORT;
                        end else if (frame.version != protocol_version) begin
                            result.frame_status = cfdd_pkg::STATUS_BAD_VER;
                        end else begin
                            result.frame_status = cfdd_pkg::STATUS_OK;
                            result.first_data   = !valid_seen_reg;
                            valid_seen_next     = 1'b1;
                            if (!pressed && was_pressed_reg &&
                                elapsed > {16'd0, takeover_holdoff_ms}) begin
                                result.takeover_event = 1'b1;
                                last_event_next       = ms_counter_reg;
                            end
                            was_pressed_next       = pressed;
                            result.steer_position  = steer_pos;
                            result.throttle_scaled = 15'(frame.throttle) * 15'd100;
                            result.brake_scaled    = 15'(frame.brake) * 15'd100;
                            result.emergency_stop  = frame.b6[5];
                            result.gear_select     = gear;
                            result.lamp_bits       = {frame.b7[7] & frame.b7[6],
                                                      frame.b7[7:1]};
                            result.raw_steering    = steer_s;
                            result.raw_throttle    = frame.throttle;
                            result.raw_brake       = frame.brake;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_seen_reg  <= 1'b0;
            was_pressed_reg <= 1'b0;
            ms_counter_reg  <= '0;
            last_event_reg  <= '0;
        end else begin
            valid_seen_reg  <= valid_seen_next;
            was_pressed_reg <= was_pressed_next;
            ms_counter_reg  <= ms_counter_next;
            last_event_reg  <= last_event_next;
        end
    end

endmodule

/* sv/cockpit_frame_deframe_decode.sv */
// Cockpit frame deframer and control decoder, top level.
// Each input transaction carries a received byte, a millisecond tick or a link
// reset in s_tuser. Every completed frame yields one output transaction whose
// m_tuser is the frame status. The block takes one input transaction per clock
// cycle while no result waits for m_tready. A transaction passes an input
// register and leaves from the result register. While a result waits for
// m_tready, a transaction in the input register holds there and s_tready
// stays low. Ticks, link resets and bytes that do not complete a frame
// produce no output. Configuration writes should be made only while no
// transaction is in flight.
module cockpit_frame_deframe_decode #(
    parameter int MAX_FRAME_LEN = cfdd_pkg::MAX_FRAME_LEN
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic [1:0]  s_tuser,   // [1:0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] first_data, [14:1] steer_position, [29:15] throttle_scaled,
    // [44:30] brake_scaled, [45] emergency_stop, [47:46] gear_select,
    // [55:48] lamp_bits, [56] takeover_event, [72:57] raw_steering,
    // [80:73] raw_throttle, [88:81] raw_brake, [95:89] zero
    output logic [95:0] m_tdata,
    output logic [1:0]  m_tuser,   // [1:0] frame_status
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    logic              in_valid_reg;
    logic [1:0]        in_func_reg;
    logic [7:0]        in_byte_reg;
    logic              advance;
    logic [7:0]        version_reg;
    logic [15:0]       holdoff_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    cfdd_pkg::result_t out_reg;
    cfdd_pkg::frame_t  frame;
    cfdd_pkg::result_t result;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_func_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            version_reg <= cfdd_pkg::PROTOCOL_VERSION_RESET;
            holdoff_reg <= cfdd_pkg::TAKEOVER_HOLDOFF_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                cfdd_pkg::CFG_PROTOCOL_VERSION: version_reg <= cfg_wdata[7:0];
                cfdd_pkg::CFG_TAKEOVER_HOLDOFF: holdoff_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    cfdd_deframer #(
        .MAX_FRAME_LEN(MAX_FRAME_LEN)
    ) u_deframer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .func    (in_func_reg),
        .rx_byte (in_byte_reg),
        .frame   (frame)
    );

    cfdd_decode u_decode (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .advance             (advance),
        .func                (in_func_reg),
        .frame               (frame),
        .protocol_version    (version_reg),
        .takeover_holdoff_ms (holdoff_reg),
        .result              (result)
    );

    always_comb begin
        if (advance && result.valid) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && result.valid) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.frame_status;
    assign m_tdata  = {7'd0,
                       out_reg.raw_brake,
                       out_reg.raw_throttle,
                       out_reg.raw_steering,
                       out_reg.takeover_event,
                       out_reg.lamp_bits,
                       out_reg.gear_select,
                       out_reg.emergency_stop,
                       out_reg.brake_scaled,
                       out_reg.throttle_scaled,
                       out_reg.steer_position,
                       out_reg.first_data};

endmodule
